>>> src/lrr_pkg.sv
// Shared types and constants for the lossless residual / RDPCM block.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package lrr_pkg;

    // Fixed field widths of the pixel and result words, the control fields and the APB port
    localparam int PIX_W  = 10;
    localparam int RES_W  = 11;
    localparam int COEF_W = 12;
    localparam int DIR_W  = 2;
    localparam int LOG2_W = 3;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Configuration register index (byte address divided by four)
    localparam logic REG_LOG2_BLOCK_WIDTH = 1'b0;

    // Reset value and minimum of the block width register
    localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd2;
    localparam logic [LOG2_W-1:0] LOG2_MIN   = 3'd2;

    // RDPCM direction codes; code 3 behaves as none
    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_HORZ = 2'd1;
    localparam logic [DIR_W-1:0] DIR_VERT = 2'd2;

    // Word held between the input stage and the result register
    typedef struct packed {
        logic signed [RES_W-1:0]  resid;
        logic signed [COEF_W-1:0] coef_base;
        logic                     use_vert;
        logic [PIX_W-1:0]         recon;
        logic                     last;
        logic                     nonzero;
    } t_stage;

endpackage

`default_nettype wire

>>> src/lrr_if.sv
// Valid/ready channel interfaces for pixel words and result words.
// Depends on lrr_pkg for the field widths.
`default_nettype none

interface lrr_pix_if import lrr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] ref_pixel;
    logic [PIX_W-1:0] pred_pixel;
    logic [DIR_W-1:0] rdpcm_direction;

    modport source (output valid, ref_pixel, pred_pixel, rdpcm_direction, input ready);
    modport sink   (input valid, ref_pixel, pred_pixel, rdpcm_direction, output ready);
endinterface

interface lrr_res_if import lrr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] coefficient;
    logic [PIX_W-1:0]         recon_pixel;
    logic                     block_last;
    logic                     block_nonzero;

    modport source (output valid, coefficient, recon_pixel, block_last, block_nonzero,
                    input ready);
    modport sink   (input valid, coefficient, recon_pixel, block_last, block_nonzero,
                    output ready);
endinterface

`default_nettype wire

>>> src/lrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lrr_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read ports; a read at the same address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/lossless_residual_rdpcm.sv
// Top level of the lossless residual path with implicit RDPCM.
// Depends on lrr_pkg, lrr_pix_if / lrr_res_if and lrr_ram (row-above buffer).
//
//   channel   direction  handshake      word
//   i_pix     in         valid/ready    ref_pixel, pred_pixel, rdpcm_direction
//   o_res     out        valid/ready    coefficient, recon_pixel, block_last/nonzero
//   APB       in         psel/penable   log2_block_width at byte address 0
//
// One word per cycle sustained while o_res.ready stays high; each word is held in the
// input stage register and then in the result register before o_res.valid rises.
// The line buffer read is issued at acceptance and its data is used as the word
// leaves the input stage, which sets the two-stage pipeline. Reset is synchronous,
// active low, and restarts the block at raster position zero; the line buffer needs
// no clearing since row zero never reads it. A stalled result holds the output
// register; the input stage keeps accepting while the result register can drain.
`default_nettype none

module lossless_residual_rdpcm
    import lrr_pkg::*;
#(
    parameter int MAX_WIDTH = 64,
    parameter int BIT_DEPTH = 10
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    lrr_pix_if.sink           i_pix,
    lrr_res_if.source         o_res,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [APB_AW-1:0] paddr,
    input  wire  [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int LOG2_MAX = $clog2(MAX_WIDTH + 1) - 1;
    localparam int POS_W    = LOG2_MAX;
    localparam int DEPTH    = 1 << POS_W;
    localparam logic [PIX_W-1:0] PIX_MASK =
        (BIT_DEPTH >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << BIT_DEPTH) - 1);
    localparam logic [LOG2_W-1:0] LOG2_TOP = LOG2_W'(LOG2_MAX);

    logic [LOG2_W-1:0]       r_log2;
    logic [POS_W-1:0]        r_col, r_row;
    logic signed [RES_W-1:0] r_left;
    logic                    r_any;
    logic                    r_s1_valid;
    t_stage                  r_s1;
    logic                    r_out_valid;
    logic signed [COEF_W-1:0] r_out_coef;
    logic [PIX_W-1:0]        r_out_recon;
    logic                    r_out_last, r_out_nonzero;

    logic                    cfg_wr, acc, out_free, s1_adv;
    logic [LOG2_W-1:0]       eff_log2;
    logic [POS_W-1:0]        last_pos;
    logic [PIX_W-1:0]        refp, predp;
    logic signed [RES_W-1:0] resid;
    logic [RES_W-1:0]        above;
    logic                    col_last, row_last;
    t_stage                  n_s1;
    logic signed [COEF_W-1:0] n_coef;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LOG2_BLOCK_WIDTH);
    assign prdata = (paddr[2] == REG_LOG2_BLOCK_WIDTH) ?
                    {{(APB_DW-LOG2_W){1'b0}}, r_log2} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2 <= LOG2_RESET;
        end else if (cfg_wr) begin
            r_log2 <= pwdata[LOG2_W-1:0];
        end
    end

    // Clamp the width to the supported range and form the last position
    always_comb begin
        if (r_log2 < LOG2_MIN) begin
            eff_log2 = LOG2_MIN;
        end else if (r_log2 > LOG2_TOP) begin
            eff_log2 = LOG2_TOP;
        end else begin
            eff_log2 = r_log2;
        end
        last_pos = POS_W'((7'd1 << eff_log2) - 7'd1);
    end

    // Handshake: the input stage moves whenever the result register can take it
    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_adv      = r_s1_valid && out_free;
    assign i_pix.ready = !r_s1_valid || out_free;
    assign acc         = i_pix.valid && i_pix.ready;

    // Residual and the horizontal / plain coefficient at acceptance
    always_comb begin
        refp     = i_pix.ref_pixel & PIX_MASK;
        predp    = i_pix.pred_pixel & PIX_MASK;
        resid    = $signed({1'b0, refp}) - $signed({1'b0, predp});
        col_last = (r_col == last_pos);
        row_last = (r_row == last_pos);

        n_s1.resid    = resid;
        n_s1.recon    = refp;
        n_s1.last     = col_last && row_last;
        n_s1.nonzero  = col_last && row_last && (r_any || (resid != '0));
        n_s1.use_vert = (i_pix.rdpcm_direction == DIR_VERT) && (r_row != '0);
        if ((i_pix.rdpcm_direction == DIR_HORZ) && (r_col != '0)) begin
            n_s1.coef_base = COEF_W'(resid) - COEF_W'(r_left);
        end else begin
            n_s1.coef_base = COEF_W'(resid);
        end
    end

    // Raster position, left residual and nonzero flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
            r_any  <= 1'b0;
        end else if (acc) begin
            r_left <= resid;
            if (col_last && row_last) begin
                r_col <= '0;
                r_row <= '0;
                r_any <= 1'b0;
            end else begin
                r_any <= r_any || (resid != '0);
                if (col_last) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // Row-above residuals: read the old word and write the new one at acceptance
    lrr_ram #(
        .WIDTH (RES_W),
        .DEPTH (DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (r_col),
        .i_wdata (resid),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (above)
    );

    // Input stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_s1;
        end
    end

    // Vertical difference against the buffered row
    assign n_coef = r_s1.use_vert ?
                    (COEF_W'(r_s1.resid) - COEF_W'($signed(above))) : r_s1.coef_base;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_coef    <= n_coef;
            r_out_recon   <= r_s1.recon;
            r_out_last    <= r_s1.last;
            r_out_nonzero <= r_s1.nonzero;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.coefficient   = r_out_coef;
    assign o_res.recon_pixel   = r_out_recon;
    assign o_res.block_last    = r_out_last;
    assign o_res.block_nonzero = r_out_nonzero;

endmodule

`default_nettype wire
